/* rtl/sec_pkg.sv */
`default_nettype none

package sec_pkg;

  // Default widths of the sample and the counter.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 32;

  // Configuration port geometry.
  localparam int KIND_WIDTH      = 3;
  localparam int CFG_INDEX_WIDTH = 2;

  // Counting kinds selected by the count_kind register.
  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_LEAVE_ZERO = 3'd0,
    KIND_MAXIMA     = 3'd1,
    KIND_MINIMA     = 3'd2,
    KIND_ANY_CROSS  = 3'd3,
    KIND_RISING     = 3'd4,
    KIND_FALLING    = 3'd5
  } kind_t;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COUNT_KIND = 2'd0,
    REG_COUNT_MIN  = 2'd1,
    REG_COUNT_MAX  = 2'd2
  } cfg_reg_t;

  // Control of the item held in the input stage.
  typedef struct packed {
    logic valid;  // an item is held
    logic fire;   // the held item is processed in this cycle
    logic mode;   // 1: reset-channel sample, 0: data sample
    logic level;  // the held sample is nonzero
  } item_ctl_t;

endpackage

`default_nettype wire

/* rtl/sec_cfg_regs.sv */
`default_nettype none

module sec_cfg_regs
  import sec_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int CFG_WIDTH   = COUNT_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]       cfg_data,
  output logic [KIND_WIDTH-1:0]           count_kind,
  output logic [COUNT_WIDTH-1:0]          count_min,
  output logic [COUNT_WIDTH-1:0]          count_max
);

  logic [KIND_WIDTH-1:0]  kind_r;
  logic [COUNT_WIDTH-1:0] min_r;
  logic [COUNT_WIDTH-1:0] max_r;
  logic                   wr;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_LEAVE_ZERO;
      min_r  <= '0;
      max_r  <= '1;
    end else if (wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COUNT_KIND: kind_r <= cfg_data[KIND_WIDTH-1:0];
        REG_COUNT_MIN:  min_r  <= cfg_data[COUNT_WIDTH-1:0];
        REG_COUNT_MAX:  max_r  <= cfg_data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign count_kind = kind_r;
  assign count_min  = min_r;
  assign count_max  = max_r;

endmodule

`default_nettype wire

/* rtl/sec_in_stage.sv */
`default_nettype none

module sec_in_stage
  import sec_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int IN_DATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [IN_DATA_WIDTH-1:0] in_tdata,
  input  wire logic                     in_tuser,
  input  wire logic                     take,
  output item_ctl_t                     ctl,
  output logic [SAMPLE_WIDTH-1:0]       value
);

  logic                    valid_r;
  logic                    valid_nxt;
  logic                    mode_r;
  logic [SAMPLE_WIDTH-1:0] value_r;
  logic                    fire;
  logic                    accept;

  // A reset-channel sample needs no result slot; a data sample waits for one.
  assign fire      = valid_r && (mode_r || take);
  assign in_tready = !valid_r || fire;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload of the accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_tuser;
      value_r <= in_tdata[SAMPLE_WIDTH-1:0];
    end
  end

  assign ctl.valid = valid_r;
  assign ctl.fire  = fire;
  assign ctl.mode  = mode_r;
  assign ctl.level = (value_r != '0);
  assign value     = value_r;

endmodule

`default_nettype wire

/* rtl/sec_detect.sv */
`default_nettype none

module sec_detect
  import sec_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire item_ctl_t               ctl,
  input  wire logic [SAMPLE_WIDTH-1:0] value,
  input  wire logic [KIND_WIDTH-1:0]   count_kind,
  output logic                         hit
);

  logic [SAMPLE_WIDTH-1:0] prev_r;
  logic [SAMPLE_WIDTH-1:0] prev_nxt;
  logic [SAMPLE_WIDTH-1:0] older_r;
  logic [SAMPLE_WIDTH-1:0] older_nxt;
  logic                    hit_kind;
  logic                    data_fire;
  logic                    prev_neg;
  logic                    new_neg;

  assign data_fire = ctl.fire && !ctl.mode;
  assign prev_neg  = prev_r[SAMPLE_WIDTH-1];
  assign new_neg   = value[SAMPLE_WIDTH-1];

  // Event test and history update for the selected kind.
  always_comb begin
    hit_kind  = 1'b0;
    prev_nxt  = prev_r;
    older_nxt = older_r;
    unique case (kind_t'(count_kind))
      KIND_LEAVE_ZERO: begin
        hit_kind = (prev_r == '0) && (value != '0);
        prev_nxt = value;
      end
      KIND_MAXIMA: begin
        hit_kind  = ($signed(older_r) < $signed(prev_r)) &&
                    ($signed(value) < $signed(prev_r));
        older_nxt = prev_r;
        prev_nxt  = value;
      end
      KIND_MINIMA: begin
        hit_kind  = ($signed(prev_r) < $signed(older_r)) &&
                    ($signed(prev_r) < $signed(value));
        older_nxt = prev_r;
        prev_nxt  = value;
      end
      KIND_ANY_CROSS: begin
        hit_kind = prev_neg != new_neg;
        prev_nxt = value;
      end
      KIND_RISING: begin
        hit_kind = prev_neg && !new_neg;
        prev_nxt = value;
      end
      KIND_FALLING: begin
        hit_kind = !prev_neg && new_neg;
        prev_nxt = value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      older_r <= '0;
    end else if (data_fire) begin
      prev_r  <= prev_nxt;
      older_r <= older_nxt;
    end
  end

  assign hit = data_fire && hit_kind;

endmodule

`default_nettype wire

/* rtl/sec_counter.sv */
`default_nettype none

module sec_counter
  import sec_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire item_ctl_t              ctl,
  input  wire logic                   hit,
  input  wire logic [COUNT_WIDTH-1:0] count_min,
  input  wire logic [COUNT_WIDTH-1:0] count_max,
  output logic                        take,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [COUNT_WIDTH-1:0]      out_count
);

  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   seen_r;
  logic                   out_valid_r;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic                   data_fire;
  logic                   reset_fire;
  logic                   over;

  // The result register is free when empty or being emptied.
  assign take       = !out_valid_r || out_tready;
  assign data_fire  = ctl.fire && !ctl.mode;
  assign reset_fire = ctl.fire && ctl.mode;

  // Increment, then wrap to the minimum on carry-out or when above the maximum.
  always_comb begin
    over      = hit && (count_r == '1);
    count_inc = hit ? count_r + 1'b1 : count_r;
    if (over || (count_inc > count_max)) begin
      count_nxt = count_min;
    end else begin
      count_nxt = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      seen_r  <= 1'b0;
    end else if (data_fire) begin
      count_r <= count_nxt;
    end else if (reset_fire) begin
      if (!seen_r && ctl.level) begin
        count_r <= count_min;
      end
      seen_r <= ctl.level;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (data_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      out_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_count  = out_count_r;

endmodule

`default_nettype wire

/* rtl/signal_event_counter.sv */
`default_nettype none

// Event counter over a stream of signed samples. It takes one sample per
// clock while the result register is free or being emptied, and returns
// the count through the input register and then the result register. The
// count update compares, increments and wraps combinationally, so that each
// sample sees the count the previous one left. A sample
// with in_tuser high belongs to the reset channel: it returns nothing, and a
// change of that channel from zero to nonzero reloads the count with
// count_min. count_kind selects leaving zero, local maxima, local minima,
// any, rising or falling zero crossings; codes 6 and 7 count nothing. The
// count wraps to count_min when it passes count_max or carries out of its
// width. Configuration is always accepted but is meant to change only while
// the block is idle.
module signal_event_counter
  import sec_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  localparam int IN_DATA_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_WIDTH = ((COUNT_WIDTH + 7) / 8) * 8,
  localparam int CFG_WIDTH = (COUNT_WIDTH > KIND_WIDTH) ? COUNT_WIDTH : KIND_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Sample channel.
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [IN_DATA_WIDTH-1:0]   in_tdata,   // value, zero padded
  input  wire logic                       in_tuser,   // mode
  // Result channel.
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [OUT_DATA_WIDTH-1:0]       out_tdata,  // count, zero padded
  // Configuration write channel.
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]       cfg_data
);

  item_ctl_t               ctl;
  logic [SAMPLE_WIDTH-1:0] value;
  logic [KIND_WIDTH-1:0]   count_kind;
  logic [COUNT_WIDTH-1:0]  count_min;
  logic [COUNT_WIDTH-1:0]  count_max;
  logic [COUNT_WIDTH-1:0]  out_count;
  logic                    take;
  logic                    hit;

  sec_cfg_regs #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .CFG_WIDTH   (CFG_WIDTH)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .count_kind (count_kind),
    .count_min  (count_min),
    .count_max  (count_max)
  );

  sec_in_stage #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .IN_DATA_WIDTH (IN_DATA_WIDTH)
  ) u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (take),
    .ctl       (ctl),
    .value     (value)
  );

  sec_detect #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_detect (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .value      (value),
    .count_kind (count_kind),
    .hit        (hit)
  );

  sec_counter #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counter (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .hit        (hit),
    .count_min  (count_min),
    .count_max  (count_max),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_count  (out_count)
  );

  assign out_tdata = OUT_DATA_WIDTH'(out_count);

  // A processed data sample always leaves a result behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fire && !ctl.mode) |=> out_tvalid)
    else $error("data sample processed without a result");

  // A reset-channel sample never changes the count in the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fire && ctl.mode) |=> $stable(out_tdata))
    else $error("reset-channel sample changed the result");

  // An empty input register always takes a new transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.valid |-> in_tready)
    else $error("input stage empty but not ready");

endmodule

`default_nettype wire
